FILE: rtl/ctfg_pkg.sv
package ctfg_pkg;

  // Field and register widths.
  localparam int SIDES_W = 6;
  localparam int SLOTS_W = 11;
  localparam int SLOT_W  = 10;
  localparam int POS_W   = 32;
  localparam int RAD_W   = 31;
  localparam int RGBA_W  = 32;
  localparam int VNUM_W  = 16;
  localparam int IDX_W   = 18;
  localparam int ANG_W   = 32;
  localparam int QUO_W   = 31;
  localparam int CW      = 34;
  localparam int TRIG_W  = 16;
  localparam int PROD_W  = RAD_W + 1 + TRIG_W;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Register limits and reset values.
  localparam logic [SIDES_W-1:0] MIN_SIDES = 6'd3;
  localparam logic [SIDES_W-1:0] MAX_SIDES = 6'd62;
  localparam logic [SIDES_W-1:0] RST_SIDES = 6'd16;
  localparam logic [SLOTS_W-1:0] MAX_SLOTS = 11'd1024;
  localparam logic [SLOTS_W-1:0] RST_SLOTS = 11'd1024;

  // Register index codes (paddr bit 2).
  localparam logic REG_SIDES = 1'b0;
  localparam logic REG_SLOTS = 1'b1;

  // Angles are radians in Q4.28.
  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 32'sd421657428;

  // Angle step for the reset side count: 2*pi / 16 as quotient and remainder.
  localparam logic [QUO_W-1:0]   RST_STEP_Q = 31'd105414357;
  localparam logic [SIDES_W-1:0] RST_STEP_R = 6'd1;

  // Rotation constants.
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] ATAN_Q28 [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879,   32'sd4193963,   32'sd2097109,  32'sd1048571,  32'sd524287,
    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,    32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024,     32'sd512
  };

  localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd32767;
  localparam logic signed [TRIG_W-1:0] TRIG_MIN = -16'sd32768;

  // Per-vertex data that travels beside the angle through the pipeline.
  typedef struct packed {
    logic              center;
    logic              last;
    logic              has_tri;
    logic [VNUM_W-1:0] vnum;
    logic [IDX_W-1:0]  index;
    logic [VNUM_W-1:0] tri_first;
    logic [VNUM_W-1:0] tri_second;
    logic [VNUM_W-1:0] tri_third;
    logic [POS_W-1:0]  cx;
    logic [POS_W-1:0]  cy;
    logic [RAD_W-1:0]  radius;
    logic [RGBA_W-1:0] rgba;
  } vtx_ctl_t;

  // Angle step from the divider to the sequencer.
  typedef struct packed {
    logic               busy;
    logic [QUO_W-1:0]   q;
    logic [SIDES_W-1:0] r;
  } step_t;

endpackage

FILE: rtl/circle_triangle_fan_generator.sv
// Triangle-fan generator for circles. Each accepted circle request whose slot
// is below circle_slots produces sides+2 vertices on the output channel, one
// per cycle unless out_stall holds the pipeline: the center, then the rim
// points from angle zero around to the closing repeat of the first one;
// requests at or above the slot count are absorbed without output. The
// sequencer issues one vertex per cycle while the output is not stalled and
// takes the next request on the cycle the previous circle's last vertex
// issues. The first vertex passes from the sequencer through a 20-stage
// rotation pipeline and the radius multipliers. Writing sides_per_circle starts
// a division that forms the per-side angle step; in_stall stays high while it
// runs. Register writes are accepted whenever the block is idle.
module circle_triangle_fan_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ctfg_pkg::SLOT_W-1:0]        in_circle_slot,
  input  logic signed [ctfg_pkg::POS_W-1:0]  in_center_x,
  input  logic signed [ctfg_pkg::POS_W-1:0]  in_center_y,
  input  logic [ctfg_pkg::RAD_W-1:0]         in_radius,
  input  logic [ctfg_pkg::RGBA_W-1:0]        in_rgba,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ctfg_pkg::VNUM_W-1:0]        out_vertex_number,
  output logic signed [ctfg_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [ctfg_pkg::POS_W-1:0]  out_pos_y,
  output logic [ctfg_pkg::RGBA_W-1:0]        out_vertex_rgba,
  output logic                               out_has_triangle,
  output logic [ctfg_pkg::IDX_W-1:0]         out_index_slot,
  output logic [ctfg_pkg::VNUM_W-1:0]        out_tri_first,
  output logic [ctfg_pkg::VNUM_W-1:0]        out_tri_second,
  output logic [ctfg_pkg::VNUM_W-1:0]        out_tri_third,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ctfg_pkg::ADDR_W-1:0]        paddr,
  input  logic [ctfg_pkg::DATA_W-1:0]        pwdata,
  output logic [ctfg_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import ctfg_pkg::*;

  logic [SIDES_W-1:0] sides_r, sides_nxt, sides_wv;
  logic [SLOTS_W-1:0] slots_r, slots_nxt, slots_wv;
  logic               wr;
  logic               div_start;
  step_t              step;

  logic               adv;
  logic               seq_vld;
  vtx_ctl_t           seq_ctl;
  logic [ANG_W-1:0]   seq_ang;
  logic               cor_vld;
  vtx_ctl_t           cor_ctl;
  logic signed [TRIG_W-1:0] cor_sin, cor_cos;
  vtx_ctl_t           out_ctl;

  // Register writes saturate into the legal range.
  always_comb begin
    wr       = psel && penable && pwrite;
    sides_wv = pwdata[SIDES_W-1:0];
    if (sides_wv < MIN_SIDES) begin
      sides_wv = MIN_SIDES;
    end else if (sides_wv > MAX_SIDES) begin
      sides_wv = MAX_SIDES;
    end
    slots_wv = pwdata[SLOTS_W-1:0];
    if (slots_wv > MAX_SLOTS) begin
      slots_wv = MAX_SLOTS;
    end
    sides_nxt = sides_r;
    slots_nxt = slots_r;
    div_start = 1'b0;
    if (wr) begin
      case (paddr[2])
        REG_SIDES: begin
          sides_nxt = sides_wv;
          div_start = 1'b1;
        end
        REG_SLOTS: begin
          slots_nxt = slots_wv;
        end
        default: begin
          sides_nxt = sides_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sides_r <= RST_SIDES;
      slots_r <= RST_SLOTS;
    end else begin
      sides_r <= sides_nxt;
      slots_r <= slots_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_SIDES: prdata = DATA_W'(sides_r);
      REG_SLOTS: prdata = DATA_W'(slots_r);
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  ctfg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (sides_wv),
    .step    (step)
  );

  ctfg_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .sides          (sides_r),
    .slots          (slots_r),
    .step           (step),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_circle_slot (in_circle_slot),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_rgba        (in_rgba),
    .vld            (seq_vld),
    .ctl            (seq_ctl),
    .ang            (seq_ang)
  );

  ctfg_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (seq_vld),
    .in_ctl  (seq_ctl),
    .in_ang  (seq_ang),
    .out_vld (cor_vld),
    .out_ctl (cor_ctl),
    .out_sin (cor_sin),
    .out_cos (cor_cos)
  );

  ctfg_place u_place (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (cor_vld),
    .in_ctl    (cor_ctl),
    .in_sin    (cor_sin),
    .in_cos    (cor_cos),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ctl   (out_ctl),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y)
  );

  assign out_vertex_number = out_ctl.vnum;
  assign out_vertex_rgba   = out_ctl.rgba;
  assign out_has_triangle  = out_ctl.has_tri;
  assign out_index_slot    = out_ctl.index;
  assign out_tri_first     = out_ctl.tri_first;
  assign out_tri_second    = out_ctl.tri_second;
  assign out_tri_third     = out_ctl.tri_third;
  assign out_last          = out_ctl.last;

endmodule

FILE: rtl/ctfg_div.sv
module ctfg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ctfg_pkg::SIDES_W-1:0] divisor,
  output ctfg_pkg::step_t             step
);
  import ctfg_pkg::*;

  localparam logic [QUO_W-1:0] DIVIDEND = TWO_PI_Q28[QUO_W-1:0];
  localparam int CNT_W = $clog2(QUO_W);

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SIDES_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [SIDES_W-1:0] div_r, div_nxt;
  logic [SIDES_W:0]   trial;
  logic [SIDES_W:0]   diff;
  logic               ge;

  // One quotient bit per cycle, restoring division of 2*pi by the side count.
  always_comb begin
    trial    = {rem_r, DIVIDEND[cnt_r]};
    diff     = trial - {1'b0, div_r};
    ge       = trial >= {1'b0, div_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = '0;
      quo_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      rem_nxt = ge ? diff[SIDES_W-1:0] : trial[SIDES_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= RST_STEP_R;
      quo_r  <= RST_STEP_Q;
      div_r  <= RST_SIDES;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      div_r  <= div_nxt;
    end
  end

  assign step.busy = busy_r;
  assign step.q    = quo_r;
  assign step.r    = rem_r;

endmodule

FILE: rtl/ctfg_seq.sv
module ctfg_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic [ctfg_pkg::SIDES_W-1:0]       sides,
  input  logic [ctfg_pkg::SLOTS_W-1:0]       slots,
  input  ctfg_pkg::step_t                    step,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ctfg_pkg::SLOT_W-1:0]        in_circle_slot,
  input  logic signed [ctfg_pkg::POS_W-1:0]  in_center_x,
  input  logic signed [ctfg_pkg::POS_W-1:0]  in_center_y,
  input  logic [ctfg_pkg::RAD_W-1:0]         in_radius,
  input  logic [ctfg_pkg::RGBA_W-1:0]        in_rgba,
  output logic                               vld,
  output ctfg_pkg::vtx_ctl_t                 ctl,
  output logic [ctfg_pkg::ANG_W-1:0]         ang
);
  import ctfg_pkg::*;

  logic               busy_r, busy_nxt;
  logic [SIDES_W-1:0] k_r, k_nxt;
  logic [VNUM_W-1:0]  vbase_r, vbase_nxt;
  logic [VNUM_W-1:0]  vnum_r, vnum_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [QUO_W-1:0]   acc_r, acc_nxt;
  logic [SIDES_W-1:0] rem_r, rem_nxt;
  logic [POS_W-1:0]   cx_r, cy_r;
  logic [RAD_W-1:0]   rad_r;
  logic [RGBA_W-1:0]  rgba_r;
  logic               vld_r;
  vtx_ctl_t           ctl_r, ctl_nxt;
  logic [ANG_W-1:0]   ang_r, ang_nxt;

  logic               at_last, center, take, hit, emit, wrap;
  logic [SIDES_W:0]   rsum;
  logic [VNUM_W:0]    vbase_full;
  logic [SIDES_W+1:0] sides3;
  logic [IDX_W-1:0]   ibase;

  // A new circle is taken when idle or on the cycle its predecessor's last vertex issues.
  always_comb begin
    center     = k_r == '0;
    at_last    = busy_r && (k_r == SIDES_W'(sides + SIDES_W'(1)));
    in_stall   = step.busy || !adv || (busy_r && !at_last);
    take       = in_valid && !in_stall;
    hit        = take && ({1'b0, in_circle_slot} < slots);
    emit       = adv && busy_r;
    vbase_full = (VNUM_W + 1)'(in_circle_slot) * (VNUM_W + 1)'({1'b0, sides} + 7'd2);
    sides3     = (SIDES_W + 2)'({2'b00, sides} + {1'b0, sides, 1'b0});
    ibase      = IDX_W'(in_circle_slot) * IDX_W'(sides3);
    rsum       = {1'b0, rem_r} + {1'b0, step.r};
    wrap       = rsum >= {1'b0, sides};
  end

  // Vertex fields for the current offset.
  always_comb begin
    ctl_nxt.center     = center;
    ctl_nxt.last       = at_last;
    ctl_nxt.has_tri    = !center && !at_last;
    ctl_nxt.vnum       = vnum_r;
    ctl_nxt.index      = ctl_nxt.has_tri ? idx_r : '0;
    ctl_nxt.tri_first  = ctl_nxt.has_tri ? vbase_r : '0;
    ctl_nxt.tri_second = ctl_nxt.has_tri ? vnum_r : '0;
    ctl_nxt.tri_third  = ctl_nxt.has_tri ? vnum_r + VNUM_W'(1) : '0;
    ctl_nxt.cx         = cx_r;
    ctl_nxt.cy         = cy_r;
    ctl_nxt.radius     = rad_r;
    ctl_nxt.rgba       = rgba_r;
    ang_nxt            = (center || at_last) ? '0 : {1'b0, acc_r};
  end

  // Counters step once per issued vertex; the angle advances by quotient and remainder.
  always_comb begin
    busy_nxt  = busy_r;
    k_nxt     = k_r;
    vbase_nxt = vbase_r;
    vnum_nxt  = vnum_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    if (emit) begin
      k_nxt    = k_r + SIDES_W'(1);
      vnum_nxt = vnum_r + VNUM_W'(1);
      if (!center) begin
        idx_nxt = idx_r + IDX_W'(3);
        acc_nxt = acc_r + step.q + QUO_W'(wrap);
        rem_nxt = wrap ? SIDES_W'(rsum - {1'b0, sides}) : rsum[SIDES_W-1:0];
      end
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (hit) begin
      busy_nxt  = 1'b1;
      k_nxt     = '0;
      vbase_nxt = vbase_full[VNUM_W-1:0];
      vnum_nxt  = vbase_full[VNUM_W-1:0];
      idx_nxt   = ibase;
      acc_nxt   = '0;
      rem_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
      if (adv) begin
        vld_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    vbase_r <= vbase_nxt;
    vnum_r  <= vnum_nxt;
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    if (hit) begin
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      rad_r  <= in_radius;
      rgba_r <= in_rgba;
    end
    if (adv) begin
      ctl_r <= ctl_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign vld = vld_r;
  assign ctl = ctl_r;
  assign ang = ang_r;

endmodule

FILE: rtl/ctfg_cordic.sv
module ctfg_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_vld,
  input  ctfg_pkg::vtx_ctl_t                 in_ctl,
  input  logic [ctfg_pkg::ANG_W-1:0]         in_ang,
  output logic                               out_vld,
  output ctfg_pkg::vtx_ctl_t                 out_ctl,
  output logic signed [ctfg_pkg::TRIG_W-1:0] out_sin,
  output logic signed [ctfg_pkg::TRIG_W-1:0] out_cos
);
  import ctfg_pkg::*;

  // Rounds a Q4.30 value to Q1.15 with saturation.
  function automatic logic signed [TRIG_W-1:0] rnd_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] s;
    s = (v + CW'(16384)) >>> 15;
    if (s > CW'(TRIG_MAX)) begin
      rnd_q15 = TRIG_MAX;
    end else if (s < CW'(TRIG_MIN)) begin
      rnd_q15 = TRIG_MIN;
    end else begin
      rnd_q15 = s[TRIG_W-1:0];
    end
  endfunction

  logic signed [ANG_W-1:0] a_in, a_wr, a_red;
  logic                    neg_red;

  logic [CORDIC_STEPS:0]   vld_s;
  logic signed [CW-1:0]    x_s   [CORDIC_STEPS+1];
  logic signed [CW-1:0]    y_s   [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_s   [CORDIC_STEPS+1];
  logic                    neg_s [CORDIC_STEPS+1];
  vtx_ctl_t                ctl_s [CORDIC_STEPS+1];
  logic signed [CW-1:0]    x_n   [CORDIC_STEPS];
  logic signed [CW-1:0]    y_n   [CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_n   [CORDIC_STEPS];

  logic signed [CW-1:0]     x_f, y_f;
  logic                     vld_r;
  vtx_ctl_t                 ctl_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  // Fold the angle into [-pi/2, pi/2]; a fold negates both results.
  always_comb begin
    a_in    = signed'(in_ang);
    a_wr    = (a_in > PI_Q28) ? a_in - TWO_PI_Q28 : a_in;
    a_red   = a_wr;
    neg_red = 1'b0;
    if (a_wr > HALF_PI_Q28) begin
      a_red   = a_wr - PI_Q28;
      neg_red = 1'b1;
    end else if (a_wr < -HALF_PI_Q28) begin
      a_red   = a_wr + PI_Q28;
      neg_red = 1'b1;
    end
  end

  // One rotation per stage.
  always_comb begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (!z_s[k][ANG_W-1]) begin
        x_n[k] = x_s[k] - (y_s[k] >>> k);
        y_n[k] = y_s[k] + (x_s[k] >>> k);
        z_n[k] = z_s[k] - ATAN_Q28[k];
      end else begin
        x_n[k] = x_s[k] + (y_s[k] >>> k);
        y_n[k] = y_s[k] - (x_s[k] >>> k);
        z_n[k] = z_s[k] + ATAN_Q28[k];
      end
    end
  end

  always_comb begin
    x_f = neg_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
    y_f = neg_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s <= '0;
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_s <= {vld_s[CORDIC_STEPS-1:0], in_vld};
      vld_r <= vld_s[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_s[0]   <= CORDIC_GAIN_Q30;
      y_s[0]   <= '0;
      z_s[0]   <= a_red;
      neg_s[0] <= neg_red;
      ctl_s[0] <= in_ctl;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        x_s[k+1]   <= x_n[k];
        y_s[k+1]   <= y_n[k];
        z_s[k+1]   <= z_n[k];
        neg_s[k+1] <= neg_s[k];
        ctl_s[k+1] <= ctl_s[k];
      end
      ctl_r <= ctl_s[CORDIC_STEPS];
      cos_r <= rnd_q15(x_f);
      sin_r <= rnd_q15(y_f);
    end
  end

  assign out_vld = vld_r;
  assign out_ctl = ctl_r;
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

FILE: rtl/ctfg_place.sv
module ctfg_place (
  input  logic                               clk,
  input  logic                               rst_n,
  output logic                               adv,
  input  logic                               in_vld,
  input  ctfg_pkg::vtx_ctl_t                 in_ctl,
  input  logic signed [ctfg_pkg::TRIG_W-1:0] in_sin,
  input  logic signed [ctfg_pkg::TRIG_W-1:0] in_cos,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ctfg_pkg::vtx_ctl_t                 out_ctl,
  output logic signed [ctfg_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [ctfg_pkg::POS_W-1:0]  out_pos_y
);
  import ctfg_pkg::*;

  logic                     p_vld_r;
  vtx_ctl_t                 p_ctl_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [PROD_W-1:0] prod_x_nxt, prod_y_nxt;
  logic signed [PROD_W-1:0] off_x, off_y;
  logic [POS_W-1:0]         pos_x_nxt, pos_y_nxt;

  logic                     valid_r;
  vtx_ctl_t                 ctl_r;
  logic [POS_W-1:0]         pos_x_r, pos_y_r;

  // The whole pipeline moves unless a finished vertex is held by the consumer.
  assign adv = !valid_r || !out_stall;

  // Radius times sine and cosine, Q17.31.
  always_comb begin
    prod_x_nxt = signed'({1'b0, in_ctl.radius}) * in_sin;
    prod_y_nxt = signed'({1'b0, in_ctl.radius}) * in_cos;
  end

  // Round to Q16.16 and add to the center, wrapping.
  always_comb begin
    off_x     = (prod_x_r + PROD_W'(16384)) >>> 15;
    off_y     = (prod_y_r + PROD_W'(16384)) >>> 15;
    pos_x_nxt = p_ctl_r.center ? p_ctl_r.cx : p_ctl_r.cx + off_x[POS_W-1:0];
    pos_y_nxt = p_ctl_r.center ? p_ctl_r.cy : p_ctl_r.cy + off_y[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= in_vld;
      valid_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ctl_r  <= in_ctl;
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      ctl_r    <= p_ctl_r;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_ctl   = ctl_r;
  assign out_pos_x = signed'(pos_x_r);
  assign out_pos_y = signed'(pos_y_r);

endmodule
